// ===== rtl/core/object_id_map_free_list_assert.svh =====
// Assertion macros used by the object ID map top level.
`ifndef OBJECT_ID_MAP_FREE_LIST_ASSERT_SVH
`define OBJECT_ID_MAP_FREE_LIST_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OIDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OIDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/oidm_pkg.sv =====
// Constants and types of the object ID map.
package oidm_pkg;

    // Table geometry and ID ranges.
    localparam int unsigned TABLE_DEPTH    = 1024;
    localparam logic [31:0] SERVER_ID_BASE = 32'hFF00_0000;

    localparam int ID_W     = 32;
    localparam int ENTRY_W  = 32;
    localparam int HANDLE_W = 30;
    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    // A head value is (index << 1) | 1, zero for an empty list.
    localparam int HEAD_W   = IDX_W + 1;

    // Bit positions in an entry word.
    localparam int FREE_BIT = 0;
    localparam int FLAG_BIT = 1;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_INSERT_NEW = 3'd0,
        REQ_INSERT_AT  = 3'd1,
        REQ_RESERVE    = 3'd2,
        REQ_REMOVE     = 3'd3,
        REQ_LOOKUP     = 3'd4
    } t_req;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Configuration register byte addresses.
    localparam logic [1:0] ADDR_MAP_SIDE = 2'd0;

    // Request sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

endpackage

// ===== rtl/core/oidm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module oidm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read; read data holds while no read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/object_id_map_free_list.sv =====
// Object ID map top level: request sequencer, counters, free-list head and tables.
//
// Every request runs through a read step and an update step: in the read step
// the entry is looked up in the client or server table RAM (one registered read
// port each), in the update step the entry word, the table counts and the
// free-list head are updated and the result beat is loaded into the output
// register. A new request is accepted only after the previous one has finished
// its update step; a held result stalls only the update step of the following
// request. The tables need no clearing pass after reset: the per-table counts
// bound every use of read data to entries that have been written, so requests
// are accepted as soon as reset is released.
module object_id_map_free_list
    import oidm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_req_type,
    input  logic [ID_W-1:0]     i_object_id,
    input  logic                i_flag_in,
    input  logic [HANDLE_W-1:0] i_handle_in,
    // Result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic [ID_W-1:0]     o_new_id,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic                o_flag_out,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    `include "object_id_map_free_list_assert.svh"

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    // Control state.
    t_state             r_state;
    logic               r_map_side;
    logic [CNT_W-1:0]   r_client_count;
    logic [CNT_W-1:0]   r_server_count;
    logic [HEAD_W-1:0]  r_free_head;
    logic               r_o_valid;

    // Request held between the read and the update cycle.
    logic [2:0]          r_req;
    logic                r_srv;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_app_idx;
    logic                r_use_head;
    logic                r_in_range;
    logic                r_at_end;
    logic                r_flag;
    logic [HANDLE_W-1:0] r_handle;

    // Output payload.
    logic                r_status;
    logic [ID_W-1:0]     r_new_id;
    logic [HANDLE_W-1:0] r_handle_out;
    logic                r_flag_out;

    // Configuration write and read.
    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_MAP_SIDE) ? {31'd0, r_map_side} : 32'd0;

    // Handshake; no beat is taken while reset is held.
    logic accept;
    logic out_free;
    logic finish;
    assign o_ready  = i_rst_n && (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign finish   = (r_state == ST_EXEC) && out_free;

    // Decode of an incoming request: table side, index and range checks.
    logic             id_srv;
    logic [ID_W-1:0]  id_off;
    logic             is_new;
    logic             sel_srv;
    logic [CNT_W-1:0] sel_cnt;
    logic [ID_W-1:0]  sel_cnt_ext;
    logic [IDX_W-1:0] head_idx;
    logic             use_head;
    logic             can_append;
    logic             in_range;
    logic             at_end;
    logic [IDX_W-1:0] rd_idx;

    always_comb begin
        id_srv      = (i_object_id >= SERVER_ID_BASE);
        id_off      = id_srv ? (i_object_id - SERVER_ID_BASE) : i_object_id;
        is_new      = (i_req_type == REQ_INSERT_NEW);
        sel_srv     = is_new ? r_map_side : id_srv;
        sel_cnt     = sel_srv ? r_server_count : r_client_count;
        sel_cnt_ext = {{(ID_W-CNT_W){1'b0}}, sel_cnt};
        head_idx    = r_free_head[HEAD_W-1:1];
        use_head    = is_new && (r_free_head != '0) && (CNT_W'(head_idx) < sel_cnt);
        can_append  = (sel_cnt != CNT_FULL);
        in_range    = (id_off < sel_cnt_ext);
        at_end      = is_new ? can_append : ((id_off == sel_cnt_ext) && can_append);
        if (is_new) begin
            rd_idx = use_head ? head_idx : sel_cnt[IDX_W-1:0];
        end else begin
            rd_idx = id_off[IDX_W-1:0];
        end
    end

    // Table memories.
    logic               cli_we;
    logic               srv_we;
    logic [IDX_W-1:0]   wr_idx;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] cli_rdata;
    logic [ENTRY_W-1:0] srv_rdata;
    logic [ENTRY_W-1:0] rdata;
    logic               wr_en;

    assign cli_we = finish && wr_en && !r_srv;
    assign srv_we = finish && wr_en && r_srv;
    assign rdata  = r_srv ? srv_rdata : cli_rdata;

    oidm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_client_table (
        .i_clk   (i_clk),
        .i_we    (cli_we),
        .i_waddr (wr_idx),
        .i_wdata (wr_data),
        .i_re    (accept && !sel_srv),
        .i_raddr (rd_idx),
        .o_rdata (cli_rdata)
    );

    oidm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_server_table (
        .i_clk   (i_clk),
        .i_we    (srv_we),
        .i_waddr (wr_idx),
        .i_wdata (wr_data),
        .i_re    (accept && sel_srv),
        .i_raddr (rd_idx),
        .o_rdata (srv_rdata)
    );

    // Update cycle: entry write-back, count and head changes, and the result.
    logic [ENTRY_W-1:0]  live_word;
    logic [ENTRY_W-1:0]  free_word;
    logic                taken;
    logic                cnt_inc;
    logic                head_we;
    logic [HEAD_W-1:0]   head_next;
    logic                n_status;
    logic [ID_W-1:0]     n_new_id;
    logic [HANDLE_W-1:0] n_handle_out;
    logic                n_flag_out;
    logic [ID_W-1:0]     side_base;

    always_comb begin
        live_word    = {r_handle, r_flag, 1'b0};
        free_word    = {{(ENTRY_W-HEAD_W-1){1'b0}}, r_free_head, 1'b1};
        side_base    = r_srv ? SERVER_ID_BASE : '0;
        taken        = r_use_head && rdata[FREE_BIT];
        wr_en        = 1'b0;
        wr_idx       = r_idx;
        wr_data      = live_word;
        cnt_inc      = 1'b0;
        head_we      = 1'b0;
        head_next    = '0;
        n_status     = STATUS_FAIL;
        n_new_id     = '0;
        n_handle_out = '0;
        n_flag_out   = 1'b0;
        case (t_req'(r_req))
            REQ_INSERT_NEW: begin
                if (taken) begin
                    // Reuse the head of the free list and follow its link.
                    wr_en     = 1'b1;
                    head_we   = 1'b1;
                    head_next = rdata[HEAD_W:1];
                    n_status  = STATUS_OK;
                    n_new_id  = side_base + {{(ID_W-IDX_W){1'b0}}, r_idx};
                end else begin
                    // A stale head drops the list; then append if there is room.
                    if (r_free_head != '0) begin
                        head_we = 1'b1;
                    end
                    if (r_at_end) begin
                        wr_en    = 1'b1;
                        wr_idx   = r_app_idx;
                        cnt_inc  = 1'b1;
                        n_status = STATUS_OK;
                        n_new_id = side_base + {{(ID_W-IDX_W){1'b0}}, r_app_idx};
                    end
                end
            end
            REQ_INSERT_AT: begin
                if (r_in_range || r_at_end) begin
                    wr_en    = 1'b1;
                    cnt_inc  = r_at_end;
                    n_status = STATUS_OK;
                end
            end
            REQ_RESERVE: begin
                if (r_srv != r_map_side) begin
                    if (r_in_range) begin
                        n_status = (rdata == '0) ? STATUS_OK : STATUS_FAIL;
                    end else if (r_at_end) begin
                        wr_en    = 1'b1;
                        wr_data  = '0;
                        cnt_inc  = 1'b1;
                        n_status = STATUS_OK;
                    end
                end
            end
            REQ_REMOVE: begin
                if ((r_srv == r_map_side) && r_in_range && !rdata[FREE_BIT]) begin
                    wr_en     = 1'b1;
                    wr_data   = free_word;
                    head_we   = 1'b1;
                    head_next = {r_idx, 1'b1};
                    n_status  = STATUS_OK;
                end
            end
            REQ_LOOKUP: begin
                if (r_in_range && !rdata[FREE_BIT]) begin
                    n_handle_out = rdata[ENTRY_W-1:2];
                    n_flag_out   = rdata[FLAG_BIT];
                    n_status     = STATUS_OK;
                end
            end
            default: begin
                n_status = STATUS_FAIL;
            end
        endcase
    end

    // Sequencer, configuration, counts, free-list head and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_map_side     <= 1'b0;
            r_client_count <= '0;
            r_server_count <= '0;
            r_free_head    <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            if (cfg_write && (paddr == ADDR_MAP_SIDE)) begin
                r_map_side <= pwdata[0];
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (finish) begin
                if (cnt_inc && r_srv) begin
                    r_server_count <= r_server_count + 1'b1;
                end
                if (cnt_inc && !r_srv) begin
                    r_client_count <= r_client_count + 1'b1;
                end
                if (head_we) begin
                    r_free_head <= head_next;
                end
            end
            if (finish) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request capture and output payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= i_req_type;
            r_srv      <= sel_srv;
            r_idx      <= rd_idx;
            r_app_idx  <= sel_cnt[IDX_W-1:0];
            r_use_head <= use_head;
            r_in_range <= in_range;
            r_at_end   <= at_end;
            r_flag     <= i_flag_in;
            r_handle   <= i_handle_in;
        end
        if (finish) begin
            r_status     <= n_status;
            r_new_id     <= n_new_id;
            r_handle_out <= n_handle_out;
            r_flag_out   <= n_flag_out;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_status;
    assign o_new_id     = r_new_id;
    assign o_handle_out = r_handle_out;
    assign o_flag_out   = r_flag_out;

    // Checks on the sequencer, the table writes, the counts, the free-list head and the result valid.
    `OIDM_ASSERT_NEXT(a_accept_exec, accept, r_state == ST_EXEC,
        "accepted request not executed")
    `OIDM_ASSERT_NOW(a_one_table_write, cli_we || srv_we,
        !(cli_we && srv_we) && (r_state == ST_EXEC), "bad table write")
    `OIDM_ASSERT_NOW(a_count_bound, 1'b1,
        (r_client_count <= CNT_FULL) && (r_server_count <= CNT_FULL), "table count overflow")
    `OIDM_ASSERT_NOW(a_head_marked, r_free_head != '0, r_free_head[0],
        "free head without marker bit")
    `OIDM_ASSERT_NOW(a_result_from_exec, $rose(r_o_valid), $past(r_state == ST_EXEC),
        "result without request")

endmodule
